FILE: hw/rtl/tpt_pkg.sv
// Package for the tween progress timer: payload structs of the request and
// response channels, command, mode, status and register codes, field widths.
// Depends on nothing.
package tpt_pkg;

   localparam int DUR_BITS = 24;
   localparam int IVL_BITS = 16;
   localparam int QUO_BITS = 16;
   localparam int PROG_BITS = 17;

   localparam logic [PROG_BITS-1:0] Q_ONE = 17'h10000;
   localparam logic [PROG_BITS-1:0] Q_HALF = 17'h08000;

   localparam logic [2:0] CMD_TICK = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_STOP = 3'd2;
   localparam logic [2:0] CMD_PAUSE = 3'd3;
   localparam logic [2:0] CMD_RESUME = 3'd4;
   localparam logic [2:0] CMD_TOGGLE = 3'd5;

   localparam logic [2:0] MODE_NORMAL = 3'd0;
   localparam logic [2:0] MODE_LOOPED = 3'd1;
   localparam logic [2:0] MODE_REVERSED = 3'd2;
   localparam logic [2:0] MODE_REV_LOOP = 3'd3;
   localparam logic [2:0] MODE_ALT = 3'd4;
   localparam logic [2:0] MODE_ALT_LOOP = 3'd5;

   localparam logic [1:0] STATUS_STOPPED = 2'd0;
   localparam logic [1:0] STATUS_RUNNING = 2'd1;
   localparam logic [1:0] STATUS_PAUSED = 2'd2;

   localparam logic REG_DURATION = 1'b0;
   localparam logic REG_INTERVAL = 1'b1;

   typedef struct packed {
      logic [2:0]  command;
      logic [15:0] delta_ms;
      logic [2:0]  start_mode;
   } req_payload_type;

   typedef struct packed {
      logic [PROG_BITS-1:0] progress;
      logic [1:0]           status;
      logic                 value_update;
      logic                 finished;
   } rsp_payload_type;

endpackage

FILE: hw/rtl/tween_progress_timer.sv
// Top level of the tween progress timer: command decode, elapsed and interval
// counters, a shared serial subtract unit for wrap and progress, APB registers.
// Depends on tpt_pkg.

// The timer takes one command per request transfer (tick, start, stop,
// pause, resume, toggle pause) and returns exactly one response transfer
// with the mapped progress in unsigned Q1.16, the run status after the
// command, and the update and finished flags. One request is in work at a
// time, and req_ready is low until its response is staged. A command whose
// raw progress is plainly one (zero duration, or elapsed at or past the
// duration) skips the division; any other command has its progress divided
// out, and a tick in a looped mode that runs past the duration first wraps
// the elapsed count. Both steps use the single shared compare-and-subtract
// unit: it first reduces the elapsed count modulo the duration, one elapsed
// bit per cycle, and then produces the 16 fraction bits of progress, one bit
// per cycle. The response sits in an output register, so the next request
// can be accepted while the previous response still waits for rsp_ready; a
// second computed response waits in its last state until that register
// frees up. The user must write the duration and interval registers over the
// APB port only while the timer is idle; the block itself does not enforce
// it. Duration lies at byte address 0 and interval at address 4.
module tween_progress_timer #(
   parameter int ELAPSED_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  tpt_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output tpt_pkg::rsp_payload_type rsp_payload,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [2:0]               paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);
   import tpt_pkg::*;

   localparam int CMP_BITS = (ELAPSED_BITS > DUR_BITS) ? ELAPSED_BITS : DUR_BITS;
   localparam int CNT_BITS = $clog2(ELAPSED_BITS);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EVAL = 5'b00010,
      ST_MOD  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type                state_ff, state_in;
   logic [DUR_BITS-1:0]      dur_ff;
   logic [IVL_BITS-1:0]      ivl_ff;
   logic [1:0]               run_status_ff, run_status_in;
   logic [2:0]               mode_ff, mode_in;
   logic [ELAPSED_BITS-1:0]  elapsed_ff, elapsed_in;
   logic [IVL_BITS-1:0]      icount_ff, icount_in;
   logic [DUR_BITS-1:0]      rem_ff, rem_in;
   logic [QUO_BITS-1:0]      quo_ff, quo_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic [PROG_BITS-1:0]     raw_ff, raw_in;
   logic                     upd_ff, upd_in;
   logic                     fin_ff, fin_in;
   logic                     chk_ff, chk_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_payload_type          rsp_ff, rsp_in;

   // Tick arithmetic on the current counters.
   logic [ELAPSED_BITS:0]    elapsed_sum;
   logic [ELAPSED_BITS-1:0]  elapsed_sat;
   logic [IVL_BITS:0]        icount_sum;
   logic                     icount_hit;

   // Elapsed versus duration, both zero-extended to a common width.
   logic [CMP_BITS-1:0]      elapsed_ext;
   logic [CMP_BITS-1:0]      dur_ext;

   // The shared compare-and-subtract unit.
   logic                     shift_bit;
   logic [DUR_BITS:0]        step_shift;
   logic [DUR_BITS:0]        step_diff;
   logic                     step_ge;
   logic [DUR_BITS-1:0]      step_rem;
   logic [CMP_BITS-1:0]      rem_ext;

   logic                     cfg_write;
   logic [2:0]               start_mode;

   function automatic logic mode_wraps(input logic [2:0] mode);
      logic result;
      case (mode) inside
         MODE_LOOPED, MODE_REV_LOOP, MODE_ALT_LOOP: result = 1'b1;
         default: result = 1'b0;
      endcase
      return result;
   endfunction

   function automatic logic [PROG_BITS-1:0] map_progress(input logic [PROG_BITS-1:0] raw,
                                                         input logic [2:0] mode);
      logic [PROG_BITS-1:0] inv;
      logic [PROG_BITS-1:0] result;
      inv = Q_ONE - raw;
      case (mode) inside
         MODE_REVERSED, MODE_REV_LOOP: result = inv;
         MODE_ALT, MODE_ALT_LOOP: begin
            // Ping-pong: rise over the first half, fall over the second.
            result = (raw <= Q_HALF) ? {raw[PROG_BITS-2:0], 1'b0}
                                     : {inv[PROG_BITS-2:0], 1'b0};
         end
         default: result = raw;
      endcase
      return result;
   endfunction

   assign elapsed_sum = {1'b0, elapsed_ff} + (ELAPSED_BITS + 1)'(req_payload.delta_ms);
   assign elapsed_sat = elapsed_sum[ELAPSED_BITS] ? {ELAPSED_BITS{1'b1}}
                                                  : elapsed_sum[ELAPSED_BITS-1:0];
   assign icount_sum = {1'b0, icount_ff} + {1'b0, req_payload.delta_ms};
   assign icount_hit = icount_sum >= {1'b0, ivl_ff};

   assign elapsed_ext = CMP_BITS'(elapsed_ff);
   assign dur_ext = CMP_BITS'(dur_ff);

   // During the wrap the elapsed bits shift in from the top; during the
   // progress division zeros shift in, which scales the dividend by 2^16.
   assign shift_bit = (state_ff == ST_MOD) ? elapsed_ff[cnt_ff] : 1'b0;
   assign step_shift = {rem_ff, shift_bit};
   assign step_diff = step_shift - {1'b0, dur_ff};
   assign step_ge = step_shift >= {1'b0, dur_ff};
   assign step_rem = step_ge ? step_diff[DUR_BITS-1:0] : step_shift[DUR_BITS-1:0];
   assign rem_ext = CMP_BITS'(step_rem);

   // Start modes that mean nothing fall back to normal playback.
   assign start_mode = (req_payload.start_mode > MODE_ALT_LOOP) ? MODE_NORMAL
                                                                : req_payload.start_mode;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in = state_ff;
      run_status_in = run_status_ff;
      mode_in = mode_ff;
      elapsed_in = elapsed_ff;
      icount_in = icount_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      raw_in = raw_ff;
      upd_in = upd_ff;
      fin_in = fin_ff;
      chk_in = chk_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               upd_in = 1'b0;
               fin_in = 1'b0;
               chk_in = 1'b0;
               state_in = ST_EVAL;
               case (req_payload.command)
                  CMD_TICK: begin
                     if (run_status_ff == STATUS_RUNNING) begin
                        elapsed_in = elapsed_sat;
                        if (ivl_ff != '0) begin
                           icount_in = icount_hit ? '0 : icount_sum[IVL_BITS-1:0];
                        end
                        // A gated tick also acts when the counter stays at
                        // zero, as a zero delta on a cleared counter does.
                        if ((ivl_ff == '0) || icount_hit || (icount_sum == '0)) begin
                           upd_in = 1'b1;
                           chk_in = 1'b1;
                        end
                     end
                  end
                  CMD_START: begin
                     if (run_status_ff == STATUS_STOPPED) begin
                        mode_in = start_mode;
                        run_status_in = STATUS_RUNNING;
                        elapsed_in = '0;
                        icount_in = '0;
                        upd_in = 1'b1;
                     end else if (run_status_ff == STATUS_PAUSED) begin
                        mode_in = start_mode;
                        run_status_in = STATUS_RUNNING;
                     end
                  end
                  CMD_STOP: begin
                     if (run_status_ff != STATUS_STOPPED) begin
                        run_status_in = STATUS_STOPPED;
                        elapsed_in = '0;
                        icount_in = '0;
                        fin_in = 1'b1;
                     end
                  end
                  CMD_PAUSE: begin
                     if (run_status_ff == STATUS_RUNNING) begin
                        run_status_in = STATUS_PAUSED;
                     end
                  end
                  CMD_RESUME: begin
                     if (run_status_ff == STATUS_PAUSED) begin
                        run_status_in = STATUS_RUNNING;
                     end
                  end
                  CMD_TOGGLE: begin
                     if (run_status_ff == STATUS_PAUSED) begin
                        run_status_in = STATUS_RUNNING;
                     end else if (run_status_ff == STATUS_RUNNING) begin
                        run_status_in = STATUS_PAUSED;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EVAL: begin
            if (chk_ff && (elapsed_ext > dur_ext)) begin
               if (mode_wraps(mode_ff)) begin
                  if (dur_ff == '0) begin
                     elapsed_in = '0;
                     raw_in = Q_ONE;
                     state_in = ST_DONE;
                  end else begin
                     rem_in = '0;
                     cnt_in = CNT_BITS'(ELAPSED_BITS - 1);
                     state_in = ST_MOD;
                  end
               end else begin
                  // The final update clamps to the duration, which is full
                  // progress; the tween then ends and the counters clear.
                  run_status_in = STATUS_STOPPED;
                  elapsed_in = '0;
                  icount_in = '0;
                  fin_in = 1'b1;
                  raw_in = Q_ONE;
                  state_in = ST_DONE;
               end
            end else if ((dur_ff == '0) || (elapsed_ext >= dur_ext)) begin
               raw_in = Q_ONE;
               state_in = ST_DONE;
            end else begin
               rem_in = elapsed_ext[DUR_BITS-1:0];
               cnt_in = CNT_BITS'(QUO_BITS - 1);
               state_in = ST_DIV;
            end
         end
         ST_MOD: begin
            rem_in = step_rem;
            if (cnt_ff == '0) begin
               // The remainder is below the duration, so the progress
               // division continues from it without a reload.
               elapsed_in = rem_ext[ELAPSED_BITS-1:0];
               cnt_in = CNT_BITS'(QUO_BITS - 1);
               state_in = ST_DIV;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DIV: begin
            rem_in = step_rem;
            quo_in = {quo_ff[QUO_BITS-2:0], step_ge};
            if (cnt_ff == '0) begin
               raw_in = {1'b0, quo_ff[QUO_BITS-2:0], step_ge};
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.progress = map_progress(raw_ff, mode_ff);
               rsp_in.status = run_status_ff;
               rsp_in.value_update = upd_ff;
               rsp_in.finished = fin_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         run_status_ff <= STATUS_STOPPED;
         mode_ff <= MODE_NORMAL;
         elapsed_ff <= '0;
         icount_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         run_status_ff <= run_status_in;
         mode_ff <= mode_in;
         elapsed_ff <= elapsed_in;
         icount_ff <= icount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      raw_ff <= raw_in;
      upd_ff <= upd_in;
      fin_ff <= fin_in;
      chk_ff <= chk_in;
      rsp_ff <= rsp_in;
   end

   // Configuration registers. The word address selects the register; a
   // write lands in the access phase, and pready is tied high.
   assign pready = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         dur_ff <= DUR_BITS'(1000);
         ivl_ff <= '0;
      end else if (cfg_write) begin
         if (paddr[2] == REG_DURATION) begin
            dur_ff <= pwdata[DUR_BITS-1:0];
         end else begin
            ivl_ff <= pwdata[IVL_BITS-1:0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == REG_INTERVAL) begin
         prdata = 32'(ivl_ff);
      end else begin
         prdata = 32'(dur_ff);
      end
   end

   // An accepted request always moves on to evaluation.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_EVAL)
      else $error("accepted request did not start evaluation");

   // The partial remainder stays below the duration while dividing.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < dur_ff)
      else $error("remainder not below duration during division");

   // A finished response always reports the stopped status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.finished |-> rsp_payload.status == STATUS_STOPPED)
      else $error("finished response with a status other than stopped");

   // Mapped progress never exceeds one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.progress <= Q_ONE)
      else $error("progress above one");

   // Once a wrap completes, the elapsed count lies below the duration.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MOD && cnt_ff == '0 |=> elapsed_ext < dur_ext)
      else $error("wrapped elapsed count not below duration");

endmodule
